/* rtl/mjdcd_pkg.sv */
package mjdcd_pkg;

  // Field widths of the stream payloads
  localparam int unsigned DayW  = 21;
  localparam int unsigned FracW = 32;
  localparam int unsigned InW   = 56;
  localparam int unsigned OutW  = 56;

  // Day-number constants of the Julian-day-to-date method
  localparam logic [21:0] MjdToJdn      = 22'd2400001;
  localparam logic [21:0] GregSwitchJdn = 22'd2299160;
  localparam logic [23:0] GregOffset4   = 24'd7468865;
  localparam logic [21:0] MarchOffset   = 22'd1524;
  localparam logic [28:0] YearOffset100 = 29'd12210;
  localparam logic [13:0] YearBaseLate  = 14'd4716;
  localparam logic [13:0] YearBaseEarly = 14'd4715;

  // Constant divisors and their reciprocals, q0 = (n * Magic) >> Shift
  localparam int unsigned ADiv   = 146097;
  localparam int unsigned AShift = 23;
  localparam int unsigned AMagic = (1 << AShift) / ADiv;
  localparam int unsigned DDiv   = 36525;
  localparam int unsigned DShift = 29;
  localparam int unsigned DMagic = (1 << DShift) / DDiv;
  localparam int unsigned GDiv   = 306001;
  localparam int unsigned GShift = 24;
  localparam int unsigned GMagic = (1 << GShift) / GDiv;

  // Month index codes
  localparam logic [3:0] MonthFeb    = 4'd2;
  localparam logic [3:0] MonthWrapAt = 4'd14;

  // Time of day carried down the date pipeline
  typedef struct packed {
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [21:0] seconds_q16;
  } tod_t;

  // floor(306001 * g / 10000): days before month index g
  function automatic logic [8:0] month_base(input logic [3:0] g);
    logic [8:0] r;
    case (g)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd30;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd91;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      4'd15:   r = 9'd459;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/mjd_to_calendar_date_core.sv */
// Throughput: one transaction per cycle unless m_axis_tready stalls the output; each
// constant division is a reciprocal multiply, a remainder stage and a one-step
// correction, so the date path sets the depth.
// Stalls propagate back through a combinational enable chain built from the per-stage valid bits; bubbles are filled.
// Reset (rst_ni low, asynchronous) clears the valid bits only; payload registers hold.
module mjd_to_calendar_date_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [20:0] mjd_day (signed), [52:21] mjd_fraction, [55:53] zero
  input  logic [55:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [12:0] year, [16:13] month, [21:17] day_of_month, [26:22] hours,
  // [32:27] minutes, [54:33] seconds_q16, [55] zero
  output logic [55:0] m_axis_tdata
);

  localparam int unsigned NS = 17;

  logic [NS:1]   v_q;
  logic [NS+1:1] en;

  // Stage registers
  logic [21:0] jdn1_q, jdn2_q, jdn3_q, jdn4_q, jdn5_q;
  logic        greg1_q, greg2_q, greg3_q, greg4_q, greg5_q;
  logic [31:0] frac1_q, f1_2_q, f2_3_q;
  logic [4:0]  hr2_q, hr3_q;
  logic [5:0]  min3_q;
  logic [22:0] na2_q, na3_q;
  logic [28:0] pa3_q;
  logic [5:0]  qa4_q, a5_q;
  logic [18:0] ra4_q;
  logic [21:0] c6_q, c7_q, c8_q, c9_q, c10_q, c11_q;
  logic [28:0] nd7_q, nd8_q;
  logic [42:0] pd8_q;
  logic [13:0] qd9_q, d10_q, d11_q, d12_q, d13_q, d14_q, d15_q, d16_q;
  logic [16:0] rd9_q;
  logic [21:0] e11_q;
  logic [9:0]  y12_q, y13_q, y14_q, y15_q, y16_q;
  logic [23:0] ng13_q, ng14_q;
  logic [29:0] pg14_q;
  logic [3:0]  g15_q, g16_q;
  logic [19:0] rg15_q;
  logic [12:0] year17_q;
  logic [3:0]  month17_q;
  logic [4:0]  dom17_q;
  mjdcd_pkg::tod_t tm_q [4:NS];

  // Next values
  logic [21:0] jdn1_d;
  logic        greg1_d;
  logic [22:0] na2_d;
  logic [36:0] t1;
  logic [37:0] t2, t3;
  logic [28:0] pa3_d;
  logic [5:0]  qa4_d, a5_d, adj5;
  logic [22:0] ra4_full;
  logic [18:0] ra4_d;
  logic [21:0] c6_d;
  logic [28:0] nd7_d;
  logic [42:0] pd8_d;
  logic [13:0] qd9_d, d10_d;
  logic [28:0] rd9_full;
  logic [16:0] rd9_d;
  logic [23:0] e_full;
  logic [21:0] e11_d;
  logic [21:0] y_full;
  logic [9:0]  y12_d;
  logic [23:0] ng13_d;
  logic [29:0] pg14_d;
  logic [3:0]  g15_d, g16_d;
  logic [23:0] rg15_full;
  logic [19:0] rg15_d;
  logic [3:0]  month17_d;
  logic [13:0] year_full;
  logic [12:0] year17_d;
  logic [9:0]  dom_full;
  logic [4:0]  dom17_d;
  mjdcd_pkg::tod_t tm4_d;

  // Advance a stage when it is empty or its successor advances
  always_comb begin
    en[NS+1] = m_axis_tready;
    for (int k = NS; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign s_axis_tready = en[1];

  // Hold valid bits; drop a stage's bit when it empties
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= s_axis_tvalid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  // Date path: Julian day number, Gregorian correction, year, month, day
  always_comb begin
    jdn1_d  = {s_axis_tdata[20], s_axis_tdata[20:0]} + mjdcd_pkg::MjdToJdn;
    greg1_d = jdn1_d > mjdcd_pkg::GregSwitchJdn;

    na2_d = 23'({jdn1_q, 2'b00} - mjdcd_pkg::GregOffset4);
    pa3_d = {6'b0, na2_q} * 29'(mjdcd_pkg::AMagic);

    qa4_d    = pa3_q[28:23];
    ra4_full = na3_q - ({17'b0, qa4_d} * 23'(mjdcd_pkg::ADiv));
    ra4_d    = ra4_full[18:0];

    a5_d = qa4_q + {5'b0, (ra4_q >= 19'(mjdcd_pkg::ADiv))};

    adj5 = 6'd1 + a5_q - {2'b0, a5_q[5:2]};
    c6_d = jdn5_q + mjdcd_pkg::MarchOffset + (greg5_q ? {16'b0, adj5} : 22'd0);

    nd7_d = ({7'b0, c6_q} * 29'd100) - mjdcd_pkg::YearOffset100;
    pd8_d = {14'b0, nd7_q} * 43'(mjdcd_pkg::DMagic);

    qd9_d    = pd8_q[42:29];
    rd9_full = nd8_q - ({15'b0, qd9_d} * 29'(mjdcd_pkg::DDiv));
    rd9_d    = rd9_full[16:0];

    d10_d = qd9_q + {13'b0, (rd9_q >= 17'(mjdcd_pkg::DDiv))};

    e_full = {10'b0, d10_q} * 24'd1461;
    e11_d  = e_full[23:2];

    y_full = c11_q - e11_q;
    y12_d  = y_full[9:0];

    ng13_d = {14'b0, y12_q} * 24'd10000;
    pg14_d = {6'b0, ng13_q} * 30'(mjdcd_pkg::GMagic);

    g15_d     = pg14_q[27:24];
    rg15_full = ng14_q - ({20'b0, g15_d} * 24'(mjdcd_pkg::GDiv));
    rg15_d    = rg15_full[19:0];

    g16_d = g15_q + {3'b0, (rg15_q >= 20'(mjdcd_pkg::GDiv))};

    month17_d = (g16_q < mjdcd_pkg::MonthWrapAt) ? (g16_q - 4'd1) : (g16_q - 4'd13);
    year_full = (month17_d > mjdcd_pkg::MonthFeb) ? (d16_q - mjdcd_pkg::YearBaseLate)
                                                  : (d16_q - mjdcd_pkg::YearBaseEarly);
    year17_d  = year_full[12:0];
    dom_full  = y16_q - {1'b0, mjdcd_pkg::month_base(g16_q)};
    dom17_d   = dom_full[4:0];
  end

  // Time path: peel hours, minutes and seconds off the fraction
  always_comb begin
    t1 = {5'b0, frac1_q} * 37'd24;
    t2 = {6'b0, f1_2_q} * 38'd60;
    t3 = {6'b0, f2_3_q} * 38'd60;
    tm4_d.hours       = hr3_q;
    tm4_d.minutes     = min3_q;
    tm4_d.seconds_q16 = t3[37:16];
  end

  // Payload registers load with their stage
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      jdn1_q  <= jdn1_d;
      greg1_q <= greg1_d;
      frac1_q <= s_axis_tdata[52:21];
    end
    if (en[2]) begin
      na2_q   <= na2_d;
      jdn2_q  <= jdn1_q;
      greg2_q <= greg1_q;
      hr2_q   <= t1[36:32];
      f1_2_q  <= t1[31:0];
    end
    if (en[3]) begin
      pa3_q   <= pa3_d;
      na3_q   <= na2_q;
      jdn3_q  <= jdn2_q;
      greg3_q <= greg2_q;
      hr3_q   <= hr2_q;
      min3_q  <= t2[37:32];
      f2_3_q  <= t2[31:0];
    end
    if (en[4]) begin
      qa4_q   <= qa4_d;
      ra4_q   <= ra4_d;
      jdn4_q  <= jdn3_q;
      greg4_q <= greg3_q;
      tm_q[4] <= tm4_d;
    end
    if (en[5]) begin
      a5_q    <= a5_d;
      jdn5_q  <= jdn4_q;
      greg5_q <= greg4_q;
    end
    if (en[6]) begin
      c6_q <= c6_d;
    end
    if (en[7]) begin
      nd7_q <= nd7_d;
      c7_q  <= c6_q;
    end
    if (en[8]) begin
      pd8_q <= pd8_d;
      nd8_q <= nd7_q;
      c8_q  <= c7_q;
    end
    if (en[9]) begin
      qd9_q <= qd9_d;
      rd9_q <= rd9_d;
      c9_q  <= c8_q;
    end
    if (en[10]) begin
      d10_q <= d10_d;
      c10_q <= c9_q;
    end
    if (en[11]) begin
      e11_q <= e11_d;
      d11_q <= d10_q;
      c11_q <= c10_q;
    end
    if (en[12]) begin
      y12_q <= y12_d;
      d12_q <= d11_q;
    end
    if (en[13]) begin
      ng13_q <= ng13_d;
      y13_q  <= y12_q;
      d13_q  <= d12_q;
    end
    if (en[14]) begin
      pg14_q <= pg14_d;
      ng14_q <= ng13_q;
      y14_q  <= y13_q;
      d14_q  <= d13_q;
    end
    if (en[15]) begin
      g15_q  <= g15_d;
      rg15_q <= rg15_d;
      y15_q  <= y14_q;
      d15_q  <= d14_q;
    end
    if (en[16]) begin
      g16_q <= g16_d;
      y16_q <= y15_q;
      d16_q <= d15_q;
    end
    if (en[17]) begin
      year17_q  <= year17_d;
      month17_q <= month17_d;
      dom17_q   <= dom17_d;
    end
    for (int k = 5; k <= NS; k++) begin
      if (en[k]) begin
        tm_q[k] <= tm_q[k-1];
      end
    end
  end

  // Present the last stage as the output transaction
  assign m_axis_tvalid = v_q[NS];
  assign m_axis_tdata  = {1'b0, tm_q[NS].seconds_q16, tm_q[NS].minutes, tm_q[NS].hours,
                          dom17_q, month17_q, year17_q};

endmodule
